/* hdl/zod_pkg.sv */
// Shared types and constants for the z-score outlier detector.
// Depends on nothing; used by the controller, the datapath and the top level.
package zod_pkg;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SCORE  = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_LENGTH    = 2'd2;

  localparam logic [1:0] REG_FEATURES = 2'd0;
  localparam logic [1:0] REG_LIMIT    = 2'd1;
  localparam logic [1:0] REG_RATE     = 2'd2;

  localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
  localparam logic [16:0] DEFAULT_RATE = 17'd6554;
  localparam logic [31:0] DEFAULT_LIMIT = 32'd196608;

  // Controller to datapath.
  typedef struct packed {
    logic start_score;  // begin divide for the held element
    logic start_update; // begin square-root update for the held element
    logic load;         // write held element into the stores
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;
  } dp_stat_t;

endpackage

/* hdl/zod_datapath.sv */
// Datapath: model memories, shared bit-serial divide/square-root unit, blend math.
// Depends on zod_pkg.
module zod_datapath #(
  parameter int MAX_FEATURES = 64,
  parameter int IW = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  zod_pkg::dp_cmd_t    cmd,
  output zod_pkg::dp_stat_t   stat,
  input  logic [IW-1:0]       idx,
  input  logic signed [31:0]  x_in,
  input  logic [31:0]         sp_in,
  input  logic [16:0]         rate,
  output logic [31:0]         z_out
);

  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam logic [31:0] ONE_Q = zod_pkg::ONE_Q16;

  logic signed [31:0] mean_mem [MAX_FEATURES];
  logic [31:0]        spread_mem [MAX_FEATURES];
  logic [AW-1:0]      addr;
  assign addr = idx[AW-1:0];

  localparam logic [2:0] P_IDLE = 3'd0, P_READ = 3'd1, P_PREP = 3'd2,
                         P_DIV = 3'd3, P_VAR = 3'd4, P_VAR2 = 3'd5,
                         P_SQRT = 3'd6, P_WB = 3'd7;

  logic [2:0]         phase;
  logic               is_div;
  logic [AW-1:0]      a_hold;  // element index held for the whole operation
  logic signed [31:0] x_hold;  // element value held for the whole operation
  logic signed [31:0] m_rd;
  logic [31:0]        s_rd;
  logic [32:0]        absd;
  logic               neg;
  logic [63:0]        acc;     // dividend bits / sqrt radicand
  logic [63:0]        rem;
  logic [31:0]        quo;
  logic [31:0]        divisor;
  logic [5:0]         cnt;
  logic [63:0]        var_q;
  logic [63:0]        d2;
  logic signed [31:0] mean_new;
  logic [48:0]        prod;
  logic [63:0]        delta_q;
  logic               var_up;

  // Bit-serial restoring divider step: 48-bit dividend, 32-bit divisor.
  logic [64:0] rem_sh;
  assign rem_sh = {rem, acc[47]};

  // Sqrt step: two radicand bits per cycle.
  logic [65:0] sq_trial;
  logic [65:0] sq_rem;
  assign sq_rem   = {rem, acc[63:62]};
  assign sq_trial = 66'({quo, 2'b01});

  logic signed [33:0] mn_ext;
  logic [32:0]        step_up;
  logic [32:0]        step_dn;
  logic [63:0]        delta;
  logic [63:0]        scaled;

  // Mean step rounds to nearest; ties go toward +infinity in both directions.
  assign step_up = prod[48:16] + 33'(prod[15]);
  assign step_dn = prod[48:16] + 33'(prod[15:0] > 16'd32768);
  assign mn_ext = neg ? $signed({m_rd[31], m_rd[31], m_rd}) - $signed({1'b0, step_dn})
                      : $signed({m_rd[31], m_rd[31], m_rd}) + $signed({1'b0, step_up});

  always_comb begin
    delta = (d2 >= var_q) ? d2 - var_q : var_q - d2;
    scaled = (rate == 17'h10000) ? delta_q
           : 64'(rate[15:0]) * 64'(delta_q[63:16])
             + 64'((48'(rate[15:0]) * delta_q[15:0]) >> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
    end else begin
      unique case (phase)
        P_IDLE: begin
          if (cmd.load) begin
            mean_mem[addr] <= x_in;
            spread_mem[addr] <= sp_in;
          end
          if (cmd.start_score || cmd.start_update) begin
            is_div <= cmd.start_score;
            a_hold <= addr;
            x_hold <= x_in;
            phase <= P_READ;
          end
        end
        P_READ: begin
          m_rd <= mean_mem[a_hold];
          s_rd <= spread_mem[a_hold];
          phase <= P_PREP;
        end
        P_PREP: begin
          neg  <= ($signed({x_hold[31], x_hold}) - $signed({m_rd[31], m_rd})) < 0;
          absd <= ($signed({x_hold[31], x_hold}) < $signed({m_rd[31], m_rd}))
                  ? 33'($signed({m_rd[31], m_rd}) - $signed({x_hold[31], x_hold}))
                  : 33'($signed({x_hold[31], x_hold}) - $signed({m_rd[31], m_rd}));
          phase <= P_DIV;
          cnt <= '0;
          rem <= '0;
          quo <= '0;
          divisor <= (s_rd == 32'd0) ? ONE_Q : s_rd;
          acc <= '0;
          var_q <= 64'(s_rd) * 64'(s_rd);
        end
        P_DIV: begin
          if (is_div) begin
            if (cnt == 6'd0) begin
              acc <= {16'd0, absd[31:0], 16'd0};
              cnt <= 6'd1;
            end else begin
              if (rem_sh >= {33'd0, divisor}) begin
                rem <= 64'(rem_sh - {33'd0, divisor});
                quo <= {quo[30:0], 1'b1};
              end else begin
                rem <= rem_sh[63:0];
                quo <= {quo[30:0], 1'b0};
              end
              acc <= acc << 1;
              if (cnt == 6'd48) phase <= P_WB;
              cnt <= cnt + 6'd1;
            end
          end else begin
            prod <= 49'(rate) * 49'(absd[31:0]);
            d2 <= 64'(absd[31:0]) * 64'(absd[31:0]);
            phase <= P_VAR;
          end
        end
        P_VAR: begin
          mean_new <= (mn_ext > 34'sh07FFFFFFF) ? 32'h7FFFFFFF
                    : (mn_ext < -34'sh080000000) ? 32'h80000000 : mn_ext[31:0];
          delta_q <= delta;
          var_up <= d2 >= var_q;
          phase <= P_VAR2;
        end
        P_VAR2: begin
          acc <= var_up ? var_q + scaled : var_q - scaled;
          rem <= '0;
          quo <= '0;
          cnt <= '0;
          phase <= P_SQRT;
        end
        P_SQRT: begin
          if (sq_rem >= sq_trial) begin
            rem <= 64'(sq_rem - sq_trial);
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= sq_rem[63:0];
            quo <= {quo[30:0], 1'b0};
          end
          acc <= acc << 2;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) phase <= P_WB;
        end
        P_WB: begin
          if (!is_div) begin
            mean_mem[a_hold] <= mean_new;
            spread_mem[a_hold] <= (quo == 32'd0) ? ONE_Q : quo;
          end
          phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  // Divider quotient is up to 48 bits; track overflow by a sticky flag.
  logic ovf;
  always_ff @(posedge clk) begin
    if (phase == P_PREP) ovf <= 1'b0;
    else if (phase == P_DIV && is_div && cnt != 6'd0 && cnt <= 6'd16
             && rem_sh >= {33'd0, divisor}) ovf <= 1'b1;
  end
  assign z_out = ovf ? 32'hFFFFFFFF : quo;
  assign stat.busy = (phase != P_IDLE);

endmodule

/* hdl/zod_control.sv */
// Controller: vector sequencing, status, peak tracking, counters, handshakes.
// Depends on zod_pkg.
module zod_control #(
  parameter int MAX_FEATURES = 64,
  parameter int IW = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic               last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_sel,
  input  logic [31:0]        cfg_data,
  output logic [IW-1:0]      idx,
  output logic [16:0]        rate,
  output zod_pkg::dp_cmd_t   cmd,
  input  zod_pkg::dp_stat_t  stat,
  input  logic [31:0]        z_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [31:0]        z_peak,
  output logic               is_flagged,
  output logic [6:0]         worst_feature,
  output logic [31:0]        checks_total,
  output logic [31:0]        flagged_total
);

  localparam logic [1:0] S_IDLE = 2'd0, S_WAIT = 2'd1, S_DONE = 2'd2;
  localparam logic [IW-1:0] MAXF = IW'(MAX_FEATURES);

  logic [1:0]    state;
  logic [6:0]    features_in_use;
  logic [31:0]   outlier_limit;
  logic [16:0]   blend_rate;
  logic          model_ready;
  logic          in_vector;
  logic [1:0]    vec_op;
  logic [IW-1:0] position;
  logic [31:0]   peak_so_far;
  logic [IW-1:0] peak_index;
  logic          was_last;
  logic          waiting_score;

  logic [1:0]    cur_op;
  logic          active;
  logic          mready_eff;
  logic          len_ok;
  logic          take;

  assign take = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign cur_op = in_vector ? vec_op : op;
  assign mready_eff = in_vector ? model_ready : (op == zod_pkg::OP_LOAD ? 1'b0 : model_ready);
  assign active = (32'(features_in_use) > 32'(position)) && (position < MAXF);
  assign idx = position;
  assign rate = (blend_rate == 17'd0 || blend_rate > 17'h10000)
                ? zod_pkg::DEFAULT_RATE : blend_rate;

  always_comb begin
    cmd.load = take && active && cur_op == zod_pkg::OP_LOAD;
    cmd.start_score  = take && active && cur_op == zod_pkg::OP_SCORE && mready_eff;
    cmd.start_update = take && active && cur_op == zod_pkg::OP_UPDATE && mready_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      features_in_use <= 7'd1;
      outlier_limit <= zod_pkg::DEFAULT_LIMIT;
      blend_rate <= zod_pkg::DEFAULT_RATE;
      model_ready <= 1'b0;
      in_vector <= 1'b0;
      vec_op <= zod_pkg::OP_LOAD;
      position <= '0;
      peak_so_far <= '0;
      peak_index <= MAXF;
      checks_total <= '0;
      flagged_total <= '0;
      out_valid <= 1'b0;
      was_last <= 1'b0;
      waiting_score <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_sel)
          zod_pkg::REG_FEATURES: features_in_use <= cfg_data[6:0];
          zod_pkg::REG_LIMIT: if (cfg_data != 32'd0) outlier_limit <= cfg_data;
          zod_pkg::REG_RATE: blend_rate <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (!in_vector) begin
              in_vector <= 1'b1;
              vec_op <= op;
              peak_so_far <= '0;
              peak_index <= MAXF;
              if (op == zod_pkg::OP_LOAD) model_ready <= 1'b0;
            end
            if (position <= MAXF) position <= position + 1'b1;
            was_last <= last;
            waiting_score <= cmd.start_score;
            state <= (cmd.start_score || cmd.start_update) ? S_WAIT : S_DONE;
          end
        end
        S_WAIT: begin
          if (!stat.busy) begin
            if (waiting_score && z_in > peak_so_far) begin
              peak_so_far <= z_in;
              peak_index <= position - 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
          if (was_last) begin
            in_vector <= 1'b0;
            position <= '0;
            peak_so_far <= '0;
            peak_index <= MAXF;
            if (vec_op != zod_pkg::OP_NONE) begin
              out_valid <= 1'b1;
              z_peak <= '0;
              is_flagged <= 1'b0;
              worst_feature <= 7'(MAX_FEATURES);
              if (vec_op == zod_pkg::OP_LOAD) begin
                status <= len_ok ? zod_pkg::ST_OK : zod_pkg::ST_LENGTH;
                model_ready <= len_ok;
              end else if (!model_ready) begin
                status <= zod_pkg::ST_NOT_READY;
              end else if (!len_ok) begin
                status <= zod_pkg::ST_LENGTH;
              end else begin
                status <= zod_pkg::ST_OK;
                if (vec_op == zod_pkg::OP_SCORE) begin
                  z_peak <= peak_so_far;
                  worst_feature <= 7'(peak_index);
                  is_flagged <= peak_so_far > outlier_limit;
                  checks_total <= checks_total + 32'd1;
                  if (peak_so_far > outlier_limit) flagged_total <= flagged_total + 32'd1;
                end
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign len_ok = features_in_use != 7'd0 && 32'(features_in_use) <= MAX_FEATURES
                  && 32'(position) == 32'(features_in_use);

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !in_ready) else $error("item taken while datapath busy");
  a_out_only_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE) else $error("result outside done");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    position <= MAXF + 1'b1) else $error("position overrun");
`endif

endmodule

/* hdl/zscore_outlier_detector.sv */
// Top level of the z-score outlier detector.
// Depends on zod_pkg, zod_control and zod_datapath.
//
//  channel   direction  handshake             payload
//  input     in         in_valid/in_ready     op, value, spread, last
//  result    out        out_valid/out_ready   status, z_peak, is_flagged, worst_feature,
//                                              checks_total, flagged_total
//  config    in         cfg_we                cfg_index, cfg_data
//
// A score request that touches the model passes through memory read, prepare,
// dividend load, 48 divide steps and write-back, and the controller then collects
// the result before the next request can be taken. An update request passes through
// read, prepare, multiply, mean and variance difference, variance blend, 32
// square-root steps and write-back, and the controller collects it in the same way.
// Load requests and requests that touch nothing go straight to the controller's done
// state. Reset is synchronous and active high; the model stores hold nothing until loaded.
// A result waits in its output register; the next request is taken once it leaves.
module zscore_outlier_detector #(
  parameter int MAX_FEATURES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [31:0] value,
  input  logic [31:0]        spread,
  input  logic               last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [31:0]        z_peak,
  output logic               is_flagged,
  output logic [6:0]         worst_feature,
  output logic [31:0]        checks_total,
  output logic [31:0]        flagged_total
);

  // Index width covers the count up to MAX_FEATURES+1.
  localparam int IW = $clog2(MAX_FEATURES + 2);

  zod_pkg::dp_cmd_t  cmd;
  zod_pkg::dp_stat_t stat;
  logic [IW-1:0]     idx;
  logic [16:0]       rate;
  logic [31:0]       z;

  zod_control #(.MAX_FEATURES(MAX_FEATURES), .IW(IW)) u_ctl (
    .clk, .rst, .in_valid, .in_ready, .op, .last,
    .cfg_we, .cfg_sel(cfg_index), .cfg_data,
    .idx, .rate, .cmd, .stat, .z_in(z),
    .out_valid, .out_ready, .status, .z_peak, .is_flagged, .worst_feature,
    .checks_total, .flagged_total
  );

  zod_datapath #(.MAX_FEATURES(MAX_FEATURES), .IW(IW)) u_dp (
    .clk, .rst, .cmd, .stat, .idx, .x_in(value), .sp_in(spread), .rate, .z_out(z)
  );

endmodule
